/* src/mtsm_pkg.sv */
// Package for the multi-track sample mixer: transaction structs, codes and constants.
// Used by mtsm_cell and multi_track_sample_mixer; depends on nothing.

package mtsm_pkg;

  localparam int unsigned GAIN_SHIFT = 12;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned PAN_W      = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned MASK_W     = 2;
  localparam int unsigned LOAD_ADR_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PROD_W     = SAMPLE_W + CFG_W + 1;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PLAY = 2'd1,
    KIND_STOP = 2'd2,
    KIND_LOAD = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEN0 = 3'd0,
    CFG_LEN1 = 3'd1,
    CFG_VOL0 = 3'd2,
    CFG_VOL1 = 3'd3,
    CFG_PAN0 = 3'd4,
    CFG_PAN1 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                   kind;
    logic                         track;
    logic                         loop;
    logic signed [ACC_W-1:0]      mix_left;
    logic signed [ACC_W-1:0]      mix_right;
    logic [LOAD_ADR_W-1:0]        load_address;
    logic signed [SAMPLE_W-1:0]   load_value;
  } mix_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] out_left;
    logic signed [ACC_W-1:0] out_right;
    logic [MASK_W-1:0]       playing_mask;
  } mix_out_t;

  typedef struct packed {
    kind_e                      kind;
    logic                       track;
    logic                       loop;
    logic [LOAD_ADR_W-1:0]      load_address;
    logic signed [SAMPLE_W-1:0] load_value;
    logic signed [ACC_W-1:0]    acc_left;
    logic signed [ACC_W-1:0]    acc_right;
    logic [MASK_W-1:0]          mask;
  } link_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

/* src/mtsm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.

module mtsm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/mtsm_cell.sv */
// One track cell of the mixer chain: track state, its configuration, its sample bank.
// Three stages: decide and read, scale, accumulate. Uses mtsm_pkg and mtsm_ram.

module mtsm_cell
  import mtsm_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH = 4096,
  parameter int unsigned IDX          = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    up_valid_i,
  output logic    up_ready_o,
  input  link_t   up_link_i,
  output logic    dn_valid_o,
  input  logic    dn_ready_i,
  output link_t   dn_link_o
);

  localparam int unsigned ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int unsigned LEN_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned EW     = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [CFG_W-1:0] len_q, vol_q;
  logic [PAN_W-1:0] pan_q;

  logic              playing_q, playing_d;
  logic              loop_q, loop_d;
  logic [ADDR_W-1:0] pos_q, pos_d;

  logic a_valid_q, b_valid_q, c_valid_q;
  link_t a_link_q, b_link_q, c_link_q, a_link_d, c_link_d;
  logic a_hit_q, b_hit_q, hit_d;
  logic signed [PROD_W-1:0] b_prod_q;

  logic adv_a, adv_b, adv_c, take;
  logic [EW-1:0] len_ext, eff_len, pos_ext, next_ext, addr_ext;
  logic [ADDR_W-1:0] start_pos, rd_addr;
  logic sel, wr_en;
  logic [SAMPLE_W-1:0] rdata;
  logic signed [ACC_W-1:0] scaled;

  assign adv_c = !c_valid_q || dn_ready_i;
  assign adv_b = !b_valid_q || adv_c;
  assign adv_a = !a_valid_q || adv_b;
  assign up_ready_o = adv_a;
  assign take = up_valid_i && adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      vol_q <= CFG_W'(1 << GAIN_SHIFT);
      pan_q <= '1;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_IDX_W'(CFG_LEN0 + IDX)) begin
        len_q <= cfg_i.data;
      end
      if (cfg_i.idx == CFG_IDX_W'(CFG_VOL0 + IDX)) begin
        vol_q <= cfg_i.data;
      end
      if (cfg_i.idx == CFG_IDX_W'(CFG_PAN0 + IDX)) begin
        pan_q <= cfg_i.data[PAN_W-1:0];
      end
    end
  end

  assign len_ext  = EW'(len_q);
  assign eff_len  = (len_ext > EW'(SAMPLE_DEPTH)) ? EW'(SAMPLE_DEPTH) : len_ext;
  assign pos_ext  = EW'(pos_q);
  assign addr_ext = EW'(up_link_i.load_address);
  assign sel      = (up_link_i.track == 1'(IDX));
  assign start_pos = (pos_ext >= eff_len) ? '0 : pos_q;
  assign next_ext  = EW'(start_pos) + EW'(1);

  always_comb begin
    playing_d = playing_q;
    loop_d    = loop_q;
    pos_d     = pos_q;
    hit_d     = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = start_pos;
    if (take) begin
      unique case (up_link_i.kind)
        KIND_TICK: begin
          if (playing_q) begin
            if (eff_len == '0) begin
              playing_d = 1'b0;
            end else if ((pos_ext >= eff_len) && !loop_q) begin
              playing_d = 1'b0;
            end else begin
              hit_d = 1'b1;
              if (next_ext >= eff_len) begin
                pos_d = '0;
                if (!loop_q) begin
                  playing_d = 1'b0;
                end
              end else begin
                pos_d = next_ext[ADDR_W-1:0];
              end
            end
          end
        end
        KIND_PLAY: begin
          if (sel && (eff_len != '0)) begin
            pos_d     = '0;
            loop_d    = up_link_i.loop;
            playing_d = 1'b1;
          end
        end
        KIND_STOP: begin
          if (sel) begin
            playing_d = 1'b0;
          end
        end
        KIND_LOAD: begin
          wr_en = sel && (addr_ext < EW'(SAMPLE_DEPTH));
        end
        default: begin
          playing_d = playing_q;
        end
      endcase
    end
  end

  always_comb begin
    a_link_d = up_link_i;
    a_link_d.mask[1'(IDX)] = playing_d;
  end

  mtsm_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(SAMPLE_DEPTH)
  ) u_bank (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(addr_ext[ADDR_W-1:0]),
    .wdata_i(up_link_i.load_value),
    .re_i   (hit_d),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  assign scaled = {{(ACC_W - PROD_W + GAIN_SHIFT){b_prod_q[PROD_W-1]}},
                   b_prod_q[PROD_W-1:GAIN_SHIFT]};

  always_comb begin
    c_link_d = b_link_q;
    if (b_hit_q && pan_q[0]) begin
      c_link_d.acc_left = b_link_q.acc_left + scaled;
    end
    if (b_hit_q && pan_q[1]) begin
      c_link_d.acc_right = b_link_q.acc_right + scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      loop_q    <= 1'b0;
      pos_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      playing_q <= playing_d;
      loop_q    <= loop_d;
      pos_q     <= pos_d;
      if (adv_a) begin
        a_valid_q <= up_valid_i;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
      if (adv_c) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_link_q <= a_link_d;
      a_hit_q  <= hit_d;
    end
    if (adv_b && a_valid_q) begin
      b_link_q <= a_link_q;
      b_hit_q  <= a_hit_q;
      b_prod_q <= $signed(rdata) * $signed({1'b0, vol_q});
    end
    if (adv_c && b_valid_q) begin
      c_link_q <= c_link_d;
    end
  end

  assign dn_valid_o = c_valid_q;
  assign dn_link_o  = c_link_q;

endmodule

/* src/multi_track_sample_mixer.sv */
// Throughput: one transaction per cycle while out_stall_i is low; each track cell runs a
// three-stage pipe of sample-bank read, gain multiply and accumulate, and the cells hand
// results down the chain.
// Reset clears track state and restores lengths to 0, volumes to unity and pans to both.
// The sample banks are not cleared by reset.
// Top level of the mixer; uses mtsm_pkg and a chain of mtsm_cell instances.

module multi_track_sample_mixer
  import mtsm_pkg::*;
#(
  parameter int unsigned TRACKS       = 2,
  parameter int unsigned SAMPLE_DEPTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mix_out_t             out_data_o
);

  cfg_wr_t cfg;
  link_t   link  [TRACKS+1];
  logic    valid [TRACKS+1];
  logic    ready [TRACKS+1];

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  always_comb begin
    link[0].kind         = kind_e'(in_data_i.kind);
    link[0].track        = in_data_i.track;
    link[0].loop         = in_data_i.loop;
    link[0].load_address = in_data_i.load_address;
    link[0].load_value   = in_data_i.load_value;
    link[0].mask         = '0;
    if (in_data_i.kind == KIND_TICK) begin
      link[0].acc_left  = in_data_i.mix_left;
      link[0].acc_right = in_data_i.mix_right;
    end else begin
      link[0].acc_left  = '0;
      link[0].acc_right = '0;
    end
  end

  assign valid[0]      = in_valid_i;
  assign in_stall_o    = !ready[0];
  assign ready[TRACKS] = !out_stall_i;

  for (genvar t = 0; t < TRACKS; t++) begin : g_cell
    mtsm_cell #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH),
      .IDX         (t)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg),
      .up_valid_i(valid[t]),
      .up_ready_o(ready[t]),
      .up_link_i (link[t]),
      .dn_valid_o(valid[t+1]),
      .dn_ready_i(ready[t+1]),
      .dn_link_o (link[t+1])
    );
  end

  assign out_valid_o             = valid[TRACKS];
  assign out_data_o.out_left     = link[TRACKS].acc_left;
  assign out_data_o.out_right    = link[TRACKS].acc_right;
  assign out_data_o.playing_mask = link[TRACKS].mask;

endmodule

/* verif/multi_track_sample_mixer_tb.sv */
// Self-checking testbench for multi_track_sample_mixer: directed rows, then random phases.
// Depends on mtsm_pkg and the mixer RTL; expected frames come from a predictor kept here.
`timescale 1ns / 1ps

module multi_track_sample_mixer_tb;
  import mtsm_pkg::*;

  localparam int unsigned DEPTH        = 4096;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_e;

  typedef struct {
    row_e             op;
    mix_in_t          item;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
    bit               typed;
    mix_out_t         frame;
  } stim_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  mix_in_t              in_data    = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  mix_out_t             out_data;

  logic [CFG_W-1:0] len_r [2] = '{13'd0, 13'd0};
  logic [CFG_W-1:0] vol_r [2] = '{13'd4096, 13'd4096};
  logic [1:0]       pan_r [2] = '{2'd3, 2'd3};
  bit               playing [2];
  bit               loop_r [2];
  logic [11:0]      pos_r [2] = '{12'd0, 12'd0};
  logic [15:0]      sample_mem [2][DEPTH];
  bit               written [2][DEPTH];

  mix_out_t  expected_frames [$];
  stim_row_t directed_rows [$];

  bit sender_idles = 1'b1;
  bit stalls_on    = 1'b1;
  int stall_left   = 0;
  int errors       = 0;
  int items_sent   = 0;
  int ticks_sent   = 0;
  int loads_sent   = 0;
  int results_seen = 0;
  int settings     = 0;

  multi_track_sample_mixer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [CFG_W-1:0] eff_len(input int t);
    return (len_r[t] > 13'(DEPTH)) ? 13'(DEPTH) : len_r[t];
  endfunction

  function automatic mix_out_t mixer_response(input mix_in_t it);
    mix_out_t          res;
    logic [31:0]       acc_l;
    logic [31:0]       acc_r;
    logic [31:0]       gain_out;
    logic signed [31:0] prod;
    logic [CFG_W-1:0]  n;
    logic [CFG_W-1:0]  p;
    res   = '0;
    acc_l = it.mix_left;
    acc_r = it.mix_right;
    case (it.kind)
      KIND_TICK: begin
        for (int t = 0; t < 2; t++) begin
          if (!playing[t]) continue;
          n = eff_len(t);
          if (n == 0) begin
            playing[t] = 1'b0;
            continue;
          end
          p = {1'b0, pos_r[t]};
          if (p >= n) begin
            if (!loop_r[t]) begin
              playing[t] = 1'b0;
              continue;
            end
            p = '0;
          end
          prod = $signed(sample_mem[t][p[11:0]]) * $signed({1'b0, vol_r[t]});
          gain_out = prod >>> GAIN_SHIFT;
          if (pan_r[t][0]) acc_l = acc_l + gain_out;
          if (pan_r[t][1]) acc_r = acc_r + gain_out;
          p = p + 1'b1;
          if (p >= n) begin
            p = '0;
            if (!loop_r[t]) playing[t] = 1'b0;
          end
          pos_r[t] = p[11:0];
        end
        res.out_left  = acc_l;
        res.out_right = acc_r;
      end
      KIND_PLAY: begin
        if (eff_len(it.track) != 0) begin
          pos_r[it.track]   = '0;
          loop_r[it.track]  = it.loop;
          playing[it.track] = 1'b1;
        end
      end
      KIND_STOP: playing[it.track] = 1'b0;
      default: begin
        sample_mem[it.track][it.load_address] = it.load_value;
        written[it.track][it.load_address]    = 1'b1;
      end
    endcase
    res.playing_mask = {playing[1], playing[0]};
    return res;
  endfunction

  // A tick must never read a sample word that was never loaded.
  function automatic bit needs_sample(input int t, output logic [11:0] addr);
    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] p;
    addr = '0;
    if (!playing[t]) return 1'b0;
    n = eff_len(t);
    if (n == 0) return 1'b0;
    p = {1'b0, pos_r[t]};
    if (p >= n) begin
      if (!loop_r[t]) return 1'b0;
      p = '0;
    end
    addr = p[11:0];
    return !written[t][addr];
  endfunction

  function automatic mix_in_t random_item();
    mix_in_t it;
    it = {$urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic logic [31:0] acc_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic mix_in_t phase_item();
    mix_in_t it;
    int      r;
    it = random_item();
    it.mix_left  = acc_value();
    it.mix_right = acc_value();
    r = $urandom_range(0, 99);
    if (r < 55) it.kind = KIND_TICK;
    else if (r < 67) it.kind = KIND_PLAY;
    else if (r < 73) it.kind = KIND_STOP;
    else begin
      it.kind = KIND_LOAD;
      if ($urandom_range(0, 4) != 0) it.load_address = 12'($urandom_range(0, 31));
    end
    return it;
  endfunction

  function automatic logic [CFG_W-1:0] pick_length(input bit allow_long);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 13'd1;
    if (allow_long && r >= 18) return (r == 18) ? 13'd4096 : 13'($urandom_range(25, 8191));
    return 13'($urandom_range(2, 24));
  endfunction

  function automatic logic [CFG_W-1:0] pick_volume();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 13'd4096;
      2: return 13'd8191;
      default: return 13'($urandom);
    endcase
  endfunction

  function automatic int idle_gap();
    int r;
    if (!sender_idles) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic mix_in_t mk_item(input kind_e k, input logic trk, input logic lp,
                                      input logic [31:0] l, input logic [31:0] r,
                                      input logic [11:0] a, input logic [15:0] v);
    mix_in_t it;
    it = {k, trk, lp, l, r, a, v};
    return it;
  endfunction

  function automatic void add_item(input mix_in_t it);
    stim_row_t row;
    row.op    = ROW_ITEM;
    row.item  = it;
    row.idx   = CFG_LEN0;
    row.data  = '0;
    row.typed = 1'b0;
    row.frame = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input mix_in_t it, input logic [31:0] l,
                                    input logic [31:0] r, input logic [1:0] m);
    stim_row_t row;
    row.op    = ROW_ITEM;
    row.item  = it;
    row.idx   = CFG_LEN0;
    row.data  = '0;
    row.typed = 1'b1;
    row.frame = {l, r, m};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    stim_row_t row;
    row.op    = ROW_CFG;
    row.item  = '0;
    row.idx   = idx;
    row.data  = value;
    row.typed = 1'b0;
    row.frame = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    // Reset state: nothing plays, a zero-length play is dropped, loads answer zero.
    add_typed(mk_item(KIND_TICK, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0),
              32'h7FFF_FFFF, 32'h8000_0000, 2'b00);
    add_typed(mk_item(KIND_PLAY, 1, 1, 0, 0, 0, 0), 0, 0, 2'b00);
    add_typed(mk_item(KIND_STOP, 0, 0, 0, 0, 0, 0), 0, 0, 2'b00);
    add_typed(mk_item(KIND_LOAD, 0, 0, 0, 0, 12'd0, 16'h7FFF), 0, 0, 2'b00);
    add_typed(mk_item(KIND_LOAD, 0, 0, 0, 0, 12'd1, 16'h8000), 0, 0, 2'b00);
    add_typed(mk_item(KIND_LOAD, 0, 0, 0, 0, 12'd2, 16'h0001), 0, 0, 2'b00);
    add_typed(mk_item(KIND_LOAD, 0, 0, 0, 0, 12'd3, 16'hFFFF), 0, 0, 2'b00);
    add_typed(mk_item(KIND_LOAD, 1, 0, 0, 0, 12'd0, 16'h8000), 0, 0, 2'b00);
    add_typed(mk_item(KIND_LOAD, 1, 0, 0, 0, 12'd1, 16'h1234), 0, 0, 2'b00);
    add_typed(mk_item(KIND_LOAD, 1, 0, 0, 0, 12'd4095, 16'h5A5A), 0, 0, 2'b00);
    // Gain above unity, one-sided pans and accumulator wrap.
    add_cfg(CFG_LEN0, 13'd4);
    add_cfg(CFG_LEN1, 13'd2);
    add_cfg(CFG_VOL0, 13'd8191);
    add_cfg(CFG_VOL1, 13'd4096);
    add_cfg(CFG_PAN0, 13'd1);
    add_cfg(CFG_PAN1, 13'd2);
    add_item(mk_item(KIND_PLAY, 0, 0, 0, 0, 0, 0));
    add_item(mk_item(KIND_PLAY, 1, 1, 0, 0, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    add_item(mk_item(KIND_PLAY, 0, 1, 0, 0, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h1234_5678, 32'hDEAD_BEEF, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0));
    // Length shrinks under a looping track, the other length drops to zero, pan and gain off.
    add_cfg(CFG_LEN0, 13'd2);
    add_cfg(CFG_LEN1, 13'd0);
    add_cfg(CFG_PAN0, 13'd0);
    add_cfg(CFG_VOL0, 13'd0);
    add_item(mk_item(KIND_TICK, 0, 0, 32'h0000_0100, 32'h0000_0200, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    // Lengths at and above the store depth.
    add_cfg(CFG_LEN0, 13'd8191);
    add_cfg(CFG_LEN1, 13'd4096);
    add_cfg(CFG_VOL0, 13'd4096);
    add_cfg(CFG_VOL1, 13'd8191);
    add_cfg(CFG_PAN0, 13'd3);
    add_cfg(CFG_PAN1, 13'd3);
    add_item(mk_item(KIND_PLAY, 1, 0, 0, 0, 0, 0));
    add_item(mk_item(KIND_PLAY, 0, 0, 0, 0, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0));
    add_item(mk_item(KIND_STOP, 0, 0, 0, 0, 0, 0));
    add_item(mk_item(KIND_TICK, 0, 0, 32'h0000_0000, 32'h0000_0000, 0, 0));
  endfunction

  task automatic drive_item(input mix_in_t it, input bit typed, input mix_out_t frame);
    mix_out_t predicted;
    int       gap;
    bit       taken;
    predicted = mixer_response(it);
    expected_frames.push_back(typed ? frame : predicted);
    items_sent++;
    if (it.kind == KIND_TICK) ticks_sent++;
    if (it.kind == KIND_LOAD) loads_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_item(input mix_in_t it, input bit typed, input mix_out_t frame);
    logic [11:0] addr;
    mix_in_t     fill;
    if (it.kind == KIND_TICK) begin
      for (int t = 0; t < 2; t++) begin
        if (needs_sample(t, addr)) begin
          fill = random_item();
          fill.kind = KIND_LOAD;
          fill.track = t[0];
          fill.load_address = addr;
          drive_item(fill, 1'b0, '0);
        end
      end
    end
    drive_item(it, typed, frame);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      CFG_LEN0: len_r[0] = value;
      CFG_LEN1: len_r[1] = value;
      CFG_VOL0: vol_r[0] = value;
      CFG_VOL1: vol_r[1] = value;
      CFG_PAN0: pan_r[0] = value[1:0];
      CFG_PAN1: pan_r[1] = value[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
    out_stall <= (stall_left != 0);
  end

  always @(negedge clk) begin
    mix_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result: L=%0d R=%0d mask=%b", out_data.out_left,
                   out_data.out_right, out_data.playing_mask);
        end
      end else begin
        want = expected_frames.pop_front();
        if (want.out_left !== out_data.out_left || want.out_right !== out_data.out_right ||
            want.playing_mask !== out_data.playing_mask) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch on result %0d: expected L=%0d R=%0d mask=%b, got L=%0d R=%0d mask=%b",
                     results_seen, want.out_left, want.out_right, want.playing_mask,
                     out_data.out_left, out_data.out_right, out_data.playing_mask);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bit prev_cfg;
    prev_cfg = 1'b0;
    build_directed();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].op == ROW_CFG) begin
        if (!prev_cfg) begin
          wait_idle();
          settings++;
        end
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        prev_cfg = 1'b1;
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].frame);
        prev_cfg = 1'b0;
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      sender_idles = (ph % 4) != 1;
      stalls_on    = (ph % 4) != 2;
      write_reg(CFG_LEN0, pick_length(ph == 3 || ph == 6));
      write_reg(CFG_LEN1, pick_length(ph == 3 || ph == 6));
      write_reg(CFG_VOL0, pick_volume());
      write_reg(CFG_VOL1, pick_volume());
      write_reg(CFG_PAN0, 13'($urandom));
      write_reg(CFG_PAN1, 13'($urandom));
      settings++;
      repeat (125) send_item(phase_item(), 1'b0, '0);
    end

    wait_idle();
    $display("Checked %0d results for %0d transactions: %0d mix ticks, %0d sample loads.",
             results_seen, items_sent, ticks_sent, loads_sent);
    $display("Ran %0d register settings with idle and stall-free stretches on both sides.",
             settings);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
